[rtl/itrs_pkg.sv]
package itrs_pkg;

    localparam int ValueWidth = 32;
    localparam int MaxAlphabet = 64;
    localparam int NumRegs = 8;
    localparam int RegWidth = 64;
    localparam int IdxWidth = $clog2(NumRegs);
    localparam int LenWidth = $clog2(MaxAlphabet + 1);
    localparam int DigitWidth = $clog2(MaxAlphabet);
    localparam int StackDepth = ValueWidth;
    localparam int SpWidth = $clog2(StackDepth + 1);
    localparam int StepWidth = $clog2(ValueWidth + 1);
    localparam int QueueDepth = 2;
    localparam int QptrWidth = $clog2(QueueDepth);

    localparam logic [7:0] CharMinus = 8'h2D;
    localparam logic [7:0] CharPlus = 8'h2B;

    typedef struct packed {
        logic                  neg;
        logic [ValueWidth-1:0] mag;
    } job_t;

    typedef struct packed {
        logic                valid;
        logic [LenWidth-1:0] len;
    } alpha_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_SIGN,
        BK_DIGITS
    } bk_state_t;

    typedef enum logic [1:0] {
        CK_IDLE,
        CK_SCAN,
        CK_DONE
    } ck_state_t;

endpackage

[rtl/itrs_alpha_check.sv]
module itrs_alpha_check (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [itrs_pkg::NumRegs*itrs_pkg::RegWidth-1:0] alpha,
    output itrs_pkg::alpha_status_t                status,
    output logic                                   done
);
    import itrs_pkg::*;

    ck_state_t state_reg, state_next;
    logic [DigitWidth-1:0] i_reg, i_next;
    logic [LenWidth-1:0] len_reg, len_next;
    logic bad_reg, bad_next;
    logic [MaxAlphabet-1:0] nz;
    logic [MaxAlphabet-1:0] dup;
    logic [7:0] ci;
    logic [LenWidth-1:0] len_c;
    logic found;

    always_comb
    begin
        for (int k = 0; k < MaxAlphabet; k++)
        begin
            nz[k] = alpha[8*k +: 8] != 8'h00;
        end
    end

    always_comb
    begin
        len_c = LenWidth'(MaxAlphabet);
        found = 1'b0;
        for (int k = 0; k < MaxAlphabet; k++)
        begin
            if (!found && !nz[k])
            begin
                len_c = LenWidth'(k);
                found = 1'b1;
            end
        end
    end

    assign ci = alpha[8*i_reg +: 8];

    always_comb
    begin
        for (int k = 0; k < MaxAlphabet; k++)
        begin
            dup[k] = (LenWidth'(k) > LenWidth'(i_reg)) && (LenWidth'(k) < len_reg)
                     && (alpha[8*k +: 8] == ci);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg;
        len_next = len_reg;
        bad_next = bad_reg;
        case (state_reg)
            CK_IDLE, CK_DONE:
            begin
                if (start)
                begin
                    state_next = CK_SCAN;
                    i_next = '0;
                    len_next = len_c;
                    bad_next = len_c < LenWidth'(2);
                end
            end
            CK_SCAN:
            begin
                if (start)
                begin
                    // A new register write restarts the scan on the updated alphabet.
                    i_next = '0;
                    len_next = len_c;
                    bad_next = len_c < LenWidth'(2);
                end
                else if (LenWidth'(i_reg) >= len_reg || bad_reg)
                begin
                    state_next = CK_DONE;
                end
                else
                begin
                    if (ci == CharMinus || ci == CharPlus || (|dup))
                    begin
                        bad_next = 1'b1;
                    end
                    if (i_reg == DigitWidth'(MaxAlphabet - 1))
                    begin
                        state_next = CK_DONE;
                    end
                    i_next = i_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = CK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CK_IDLE;
            i_reg <= '0;
            len_reg <= '0;
            bad_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            i_reg <= i_next;
            len_reg <= len_next;
            bad_reg <= bad_next;
        end
    end

    assign done = state_reg == CK_DONE;
    assign status.valid = !bad_reg;
    assign status.len = len_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CK_DONE && !bad_reg) |-> len_reg >= LenWidth'(2))
        else $error("valid alphabet shorter than two");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CK_DONE && !bad_reg) |-> len_reg <= LenWidth'(MaxAlphabet))
        else $error("alphabet length out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CK_IDLE && start) |=> state_reg == CK_SCAN)
        else $error("check did not start");
endmodule

[rtl/itrs_front.sv]
module itrs_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [itrs_pkg::ValueWidth-1:0] number,
    input  itrs_pkg::alpha_status_t             status,
    input  logic                                check_done,
    output itrs_pkg::job_t                      job,
    output logic                                job_valid,
    input  logic                                job_pop
);
    import itrs_pkg::*;

    job_t q_reg [QueueDepth];
    logic [QptrWidth-1:0] wp_reg, rp_reg;
    logic [QptrWidth:0] cnt_reg;
    logic acc, wr, rd;
    logic [ValueWidth-1:0] v;

    assign full = !check_done || cnt_reg == (QptrWidth+1)'(QueueDepth);
    assign acc = push && !full;
    assign wr = acc && status.valid;
    assign rd = job_pop && job_valid;
    assign job_valid = cnt_reg != '0;
    assign job = q_reg[rp_reg];
    assign v = number;

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            q_reg[wp_reg].neg <= v[ValueWidth-1];
            q_reg[wp_reg].mag <= v[ValueWidth-1] ? (~v + 1'b1) : v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (rd)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QptrWidth+1)'(wr) - (QptrWidth+1)'(rd);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (QptrWidth+1)'(QueueDepth))
        else $error("job queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr && !rd) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("job count lost a write");
endmodule

[rtl/itrs_back.sv]
module itrs_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  itrs_pkg::job_t                      job,
    input  logic                                job_valid,
    output logic                                job_pop,
    input  logic [itrs_pkg::LenWidth-1:0]       len,
    input  logic [itrs_pkg::NumRegs*itrs_pkg::RegWidth-1:0] alpha,
    output logic                                empty,
    input  logic                                pop,
    output logic [7:0]                          symbol,
    output logic                                last,
    output logic                                busy
);
    import itrs_pkg::*;

    bk_state_t state_reg, state_next;
    logic [DigitWidth-1:0] stack_mem [StackDepth];
    logic [SpWidth-1:0] sp_reg, sp_next;
    logic neg_reg, neg_next;
    logic [ValueWidth-1:0] quo_reg, quo_next, dvd_reg, dvd_next;
    logic [LenWidth-1:0] rem_reg, rem_next;
    logic [StepWidth-1:0] bit_reg, bit_next;
    logic [LenWidth:0] trial;
    logic push_digit;
    logic [DigitWidth-1:0] top_digit_reg;
    logic ob_valid_reg, ob_valid_next;
    logic [7:0] ob_sym_reg, ob_sym_next;
    logic ob_last_reg, ob_last_next;
    logic ob_free;

    assign ob_free = !ob_valid_reg || pop;
    assign trial = {rem_reg, dvd_reg[ValueWidth-1]};

    always_comb
    begin
        state_next = state_reg;
        sp_next = sp_reg;
        neg_next = neg_reg;
        quo_next = quo_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        bit_next = bit_reg;
        job_pop = 1'b0;
        push_digit = 1'b0;
        ob_valid_next = ob_valid_reg && !pop;
        ob_sym_next = ob_sym_reg;
        ob_last_next = ob_last_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop = 1'b1;
                    neg_next = job.neg;
                    dvd_next = job.mag;
                    quo_next = '0;
                    rem_next = '0;
                    bit_next = '0;
                    sp_next = '0;
                    state_next = BK_DIVIDE;
                end
            end
            BK_DIVIDE:
            begin
                if (bit_reg == StepWidth'(ValueWidth))
                begin
                    push_digit = 1'b1;
                    sp_next = sp_reg + 1'b1;
                    if (quo_reg == '0)
                    begin
                        state_next = neg_reg ? BK_SIGN : BK_DIGITS;
                    end
                    else
                    begin
                        dvd_next = quo_reg;
                        quo_next = '0;
                        rem_next = '0;
                        bit_next = '0;
                    end
                end
                else
                begin
                    dvd_next = dvd_reg << 1;
                    bit_next = bit_reg + 1'b1;
                    if (trial >= {1'b0, len})
                    begin
                        rem_next = LenWidth'(trial - {1'b0, len});
                        quo_next = {quo_reg[ValueWidth-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = LenWidth'(trial);
                        quo_next = {quo_reg[ValueWidth-2:0], 1'b0};
                    end
                end
            end
            BK_SIGN:
            begin
                if (ob_free)
                begin
                    ob_valid_next = 1'b1;
                    ob_sym_next = CharMinus;
                    ob_last_next = 1'b0;
                    state_next = BK_DIGITS;
                end
            end
            BK_DIGITS:
            begin
                if (ob_free)
                begin
                    ob_valid_next = 1'b1;
                    ob_sym_next = alpha[8*top_digit_reg +: 8];
                    ob_last_next = sp_reg == SpWidth'(1);
                    sp_next = sp_reg - 1'b1;
                    if (sp_reg == SpWidth'(1))
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // The top of the stack is read into a register ahead of use; a digit pushed at this
    // edge is the new top and is taken straight from the divider.
    always_ff @(posedge clk)
    begin
        if (push_digit)
        begin
            stack_mem[sp_reg[SpWidth-2:0]] <= DigitWidth'(rem_reg);
            top_digit_reg <= DigitWidth'(rem_reg);
        end
        else
        begin
            top_digit_reg <= stack_mem[sp_next[SpWidth-2:0] - 1'b1];
        end
        ob_sym_reg <= ob_sym_next;
        ob_last_reg <= ob_last_next;
        quo_reg <= quo_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            sp_reg <= '0;
            bit_reg <= '0;
            ob_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg <= sp_next;
            bit_reg <= bit_next;
            ob_valid_reg <= ob_valid_next;
        end
    end

    assign empty = !ob_valid_reg;
    assign symbol = ob_sym_reg;
    assign last = ob_last_reg;
    assign busy = state_reg != BK_IDLE || ob_valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SpWidth'(StackDepth))
        else $error("digit stack overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_DIGITS |-> sp_reg != '0)
        else $error("digit state with empty stack");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_DIVIDE |-> rem_reg < len)
        else $error("remainder not below radix");
endmodule

[rtl/integer_to_radix_symbols.sv]
// Converts signed 32-bit values to symbol strings in the radix of a
// configured alphabet. Input beats enter through push and full; each
// result beat carries one symbol and a last flag and is taken with pop
// while empty is low. A negative value gives a minus sign first.
// Configuration is written through cfg_we, cfg_index and cfg_data; the
// user must write it only while the block is idle, which the block itself
// does not enforce. After reset and after every alphabet write, the block
// holds full high while it checks the alphabet. Each digit is produced by
// a bit-serial restoring divider and pushed on a digit stack. A two-entry
// job queue lets the next number be accepted while the current one
// converts. When the receiver stalls, the output register holds its beat
// and the conversion waits; accepting input continues until the queue
// fills. Reset clears the alphabet and discards all queued and pending
// beats.
module integer_to_radix_symbols (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [itrs_pkg::ValueWidth-1:0] number,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [7:0]                           symbol,
    output logic                                 last,
    input  logic                                 cfg_we,
    input  logic [itrs_pkg::IdxWidth-1:0]        cfg_index,
    input  logic [itrs_pkg::RegWidth-1:0]        cfg_data
);
    import itrs_pkg::*;

    logic [NumRegs*RegWidth-1:0] alpha_reg;
    logic start_reg;
    alpha_status_t status;
    logic check_done;
    job_t job;
    logic job_valid, job_pop, busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= '0;
            start_reg <= 1'b1;
        end
        else
        begin
            start_reg <= cfg_we;
            if (cfg_we)
            begin
                alpha_reg[RegWidth*cfg_index +: RegWidth] <= cfg_data;
            end
        end
    end

    itrs_alpha_check u_check (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_reg),
        .alpha  (alpha_reg),
        .status (status),
        .done   (check_done)
    );

    itrs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .number     (number),
        .status     (status),
        .check_done (check_done && !start_reg && !cfg_we),
        .job        (job),
        .job_valid  (job_valid),
        .job_pop    (job_pop)
    );

    itrs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .len       (status.len),
        .alpha     (alpha_reg),
        .empty     (empty),
        .pop       (pop),
        .symbol    (symbol),
        .last      (last),
        .busy      (busy)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty && $stable(symbol) && $stable(last))
        else $error("stalled beat changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> empty)
        else $error("beat shown while idle");
endmodule

[sim/tb_integer_to_radix_symbols.sv]
module tb_integer_to_radix_symbols;
    import itrs_pkg::*;

    typedef struct {
        logic [7:0] sym;
        logic       lst;
    } symbol_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic [ValueWidth-1:0] number = '0;
    logic cfg_we = 1'b0;
    logic [IdxWidth-1:0] cfg_index = '0;
    logic [RegWidth-1:0] cfg_data = '0;
    logic full;
    logic empty;
    logic [7:0] symbol;
    logic last;

    logic [RegWidth-1:0] alphabet_shadow [NumRegs];
    logic [ValueWidth-1:0] pending_numbers [$];
    symbol_beat_t expected_symbols [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit sender_pause = 1'b0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int mismatches = 0;
    int cycle_count = 0;

    integer_to_radix_symbols dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .number(number),
        .empty(empty),
        .pop(pop),
        .symbol(symbol),
        .last(last),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [7:0] alphabet_byte(int k);
        return alphabet_shadow[k >> 3][(k & 7) * 8 +: 8];
    endfunction

    function automatic int alphabet_length();
        int k;
        k = 0;
        while (k < MaxAlphabet && alphabet_byte(k) != 8'h00)
            k++;
        return k;
    endfunction

    function automatic bit alphabet_usable(int len);
        logic [7:0] c;
        if (len < 2)
            return 1'b0;
        for (int i = 0; i < len; i++)
        begin
            c = alphabet_byte(i);
            if (c == CharMinus || c == CharPlus)
                return 1'b0;
            for (int j = i + 1; j < len; j++)
                if (alphabet_byte(j) == c)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_symbols(logic [ValueWidth-1:0] value);
        int len;
        int count;
        logic [DigitWidth-1:0] digits [StackDepth];
        longint unsigned mag;
        symbol_beat_t b;
        len = alphabet_length();
        if (!alphabet_usable(len))
            return;
        mag = value[ValueWidth-1] ? longint'(~value + 1'b1) & 64'hFFFF_FFFF
                                  : longint'(value);
        count = 0;
        do
        begin
            digits[count] = DigitWidth'(mag % len);
            count++;
            mag = mag / len;
        end
        while (mag != 0);
        if (value[ValueWidth-1])
        begin
            b.sym = CharMinus;
            b.lst = 1'b0;
            expected_symbols.push_back(b);
        end
        while (count > 0)
        begin
            count--;
            b.sym = alphabet_byte(digits[count]);
            b.lst = (count == 0);
            expected_symbols.push_back(b);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                predict_symbols(number);
                void'(pending_numbers.pop_front());
            end
            if (pending_numbers.size() > 0 && !sender_pause
                && $urandom_range(99) >= tx_idle_pct)
            begin
                push <= 1'b1;
                number <= pending_numbers[0];
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_requests != hold_served)
            begin
                hold_served <= hold_requests;
                hold_left <= 2500;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        symbol_beat_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_symbols.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: symbol %h last %b", symbol, last);
                end
                else
                begin
                    want = expected_symbols.pop_front();
                    if (want.sym !== symbol || want.lst !== last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected symbol %h last %b, got %h %b",
                                     want.sym, want.lst, symbol, last);
                    end
                end
            end
            if (hold_requests != hold_served || hold_left > 0)
            begin
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic drain();
        while (pending_numbers.size() > 0 || expected_symbols.size() > 0)
            @(posedge clk);
        repeat (1200) @(posedge clk);
    endtask

    task automatic load_alphabet(logic [RegWidth-1:0] regs [NumRegs]);
        for (int r = 0; r < NumRegs; r++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= IdxWidth'(r);
            cfg_data <= regs[r];
            alphabet_shadow[r] = regs[r];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic void pack_string(string s, ref logic [RegWidth-1:0] regs [NumRegs]);
        for (int r = 0; r < NumRegs; r++)
            regs[r] = '0;
        for (int k = 0; k < s.len(); k++)
            regs[k >> 3][(k & 7) * 8 +: 8] = s[k];
    endfunction

    function automatic void random_alphabet(int len,
                                            ref logic [RegWidth-1:0] regs [NumRegs]);
        bit used [256];
        logic [7:0] c;
        for (int i = 0; i < 256; i++)
            used[i] = 1'b0;
        used[0] = 1'b1;
        used[CharMinus] = 1'b1;
        used[CharPlus] = 1'b1;
        for (int k = 0; k < MaxAlphabet; k++)
        begin
            if (k < len)
            begin
                do
                    c = 8'($urandom);
                while (used[c]);
                used[c] = 1'b1;
            end
            else if (k == len)
                c = 8'h00;
            else
                c = 8'($urandom);
            regs[k >> 3][(k & 7) * 8 +: 8] = c;
        end
    endfunction

    function automatic logic [ValueWidth-1:0] random_number();
        case ($urandom_range(5))
            0: return ValueWidth'($urandom_range(300));
            1: return -ValueWidth'($urandom_range(1, 300));
            2: return {1'b1, {(ValueWidth-1){1'b0}}} + ValueWidth'($urandom_range(3));
            3: return {1'b0, {(ValueWidth-1){1'b1}}} - ValueWidth'($urandom_range(3));
            default: return ValueWidth'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [RegWidth-1:0] regs [NumRegs];
        int len_tab [8];
        len_tab = '{64, 16, 2, 37, 10, 3, 58, 36};
        for (int r = 0; r < NumRegs; r++)
            alphabet_shadow[r] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        pack_string("0123456789", regs);
        load_alphabet(regs);
        pending_numbers = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd12345};
        drain();

        random_alphabet(64, regs);
        load_alphabet(regs);
        pending_numbers = '{32'd0, 32'd63, 32'd64, -32'sd64, 32'h7FFF_FFFF, 32'h8000_0000};
        drain();

        pack_string("01", regs);
        load_alphabet(regs);
        pending_numbers = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000};
        drain();

        pack_string("", regs);
        load_alphabet(regs);
        pending_numbers = '{32'd5};
        drain();
        pack_string("A", regs);
        load_alphabet(regs);
        pending_numbers = '{-32'sd5};
        drain();
        pack_string("01+", regs);
        load_alphabet(regs);
        pending_numbers = '{32'd7};
        drain();
        pack_string("-01", regs);
        load_alphabet(regs);
        pending_numbers = '{32'd7};
        drain();
        pack_string("0120", regs);
        load_alphabet(regs);
        pending_numbers = '{-32'sd7};
        drain();

        for (int mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0: begin tx_idle_pct = 0; rx_idle_pct = 0; end
                1: begin tx_idle_pct = 85; rx_idle_pct = 0; end
                2: begin tx_idle_pct = 0; rx_idle_pct = 85; end
                default: begin tx_idle_pct = 22; rx_idle_pct = 22; end
            endcase
            for (int sub = 0; sub < 2; sub++)
            begin
                random_alphabet(len_tab[mode * 2 + sub], regs);
                load_alphabet(regs);
                if (mode == 0 && sub == 0)
                    hold_requests++;
                for (int n = 0; n < 28; n++)
                    pending_numbers.push_back(random_number());
                if (mode == 3 && sub == 0)
                begin
                    while (pending_numbers.size() > 14)
                        @(posedge clk);
                    sender_pause = 1'b1;
                    while (expected_symbols.size() > 0)
                        @(posedge clk);
                    sender_pause = 1'b0;
                end
                for (int n = 0; n < 28; n++)
                    pending_numbers.push_back(random_number());
                drain();
            end
        end

        if (mismatches == 0 && expected_symbols.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
